// ----- hw/rtl/sobel_pkg.sv -----
// Package for the streaming Sobel edge detector.
// Holds frame limits, register reset values, register index codes and shared structs.
// No dependencies.
package sobel_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W    = 8;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int CWIDTH_W = 11;
  localparam int CHEIGHT_W = 13;
  localparam int THR_W    = 21;
  localparam int CFG_DATA_W = 21;
  localparam int GRAD_W   = 11;
  localparam int SQ_W     = 20;

  localparam logic [CWIDTH_W-1:0]  WIDTH_RESET  = CWIDTH_W'(1024);
  localparam logic [CHEIGHT_W-1:0] HEIGHT_RESET = CHEIGHT_W'(768);
  localparam logic [THR_W-1:0]     THR_RESET    = THR_W'(5852);

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_THRESHOLD_SQ = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [COL_W-1:0] width_m1;
    logic [ROW_W-1:0] height_m1;
  } frame_dims_t;

  typedef struct packed {
    logic             emit;
    logic             last_of_frame;
    logic [COL_W-1:0] center_col;
    logic [ROW_W-1:0] center_row;
  } pix_meta_t;

endpackage

// ----- hw/rtl/sobel_ifs.sv -----
// Channel interfaces: pixel input, edge result output, configuration write.
// Depends on sobel_pkg.
interface sobel_pix_if import sobel_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface sobel_res_if import sobel_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             edge_res;
  logic [COL_W-1:0] center_col;
  logic [ROW_W-1:0] center_row;
  logic             last_of_frame;

  modport source (output valid, output edge_res, output center_col, output center_row,
                  output last_of_frame, input ready);
  modport sink   (input valid, input edge_res, input center_col, input center_row,
                  input last_of_frame, output ready);
endinterface

interface sobel_cfg_if import sobel_pkg::*; ();
  logic                  valid;
  logic                  ready;
  cfg_index_t            index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/sobel_edge_threshold_stream.sv -----
// Top level of the streaming 3x3 Sobel edge detector with squared threshold.
// Depends on sobel_pkg, sobel_ifs, sobel_cfg_regs, sobel_line_buf, sobel_grad.
//
//   channel  dir  transaction
//   pix      in   one 8-bit pixel, raster order
//   res      out  edge flag, center column/row, last-of-frame (interior pixels only)
//   cfg      in   register write: index, data (always ready)
//
// One pixel per cycle while the pipeline advances; each result passes the stages below before res.valid rises.
// Pipeline: buffer read, window shift, Sobel sums, squares, compare into result register.
// The whole pipeline advances when the result register is empty or being taken,
// so pix.ready follows res.ready while a result is held.
// Synchronous reset clears counters, valids and config registers; data registers and row buffers are not cleared.
module sobel_edge_threshold_stream import sobel_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  sobel_pix_if.sink    pix,
  sobel_res_if.source  res,
  sobel_cfg_if.sink    cfg
);

  frame_dims_t      dims;
  logic [THR_W-1:0] threshold_sq;
  logic             en;
  logic             s1_valid;
  logic [PIX_W-1:0] s1_pixel;
  logic [PIX_W-1:0] top;
  logic [PIX_W-1:0] mid;
  pix_meta_t        s1_meta;

  assign en        = !res.valid || res.ready;
  assign pix.ready = en;

  sobel_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .dims         (dims),
    .threshold_sq (threshold_sq)
  );

  sobel_line_buf u_line (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .pix_valid (pix.valid),
    .pixel     (pix.pixel),
    .dims      (dims),
    .s1_valid  (s1_valid),
    .s1_pixel  (s1_pixel),
    .top       (top),
    .mid       (mid),
    .s1_meta   (s1_meta)
  );

  sobel_grad u_grad (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .s1_valid     (s1_valid),
    .s1_pixel     (s1_pixel),
    .top          (top),
    .mid          (mid),
    .s1_meta      (s1_meta),
    .threshold_sq (threshold_sq),
    .res          (res)
  );

endmodule

// ----- hw/rtl/sobel_cfg_regs.sv -----
// Configuration registers and clamped frame dimensions.
// Depends on sobel_pkg and sobel_cfg_if.
module sobel_cfg_regs import sobel_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  sobel_cfg_if.sink         cfg,
  output frame_dims_t       dims,
  output logic [THR_W-1:0]  threshold_sq
);

  logic [CWIDTH_W-1:0]  image_width;
  logic [CHEIGHT_W-1:0] image_height;
  logic [CWIDTH_W-1:0]  width_eff;
  logic [CHEIGHT_W-1:0] height_eff;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      threshold_sq <= THR_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg.data[CWIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg.data[CHEIGHT_W-1:0];
        CFG_THRESHOLD_SQ: threshold_sq <= cfg.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width < CWIDTH_W'(3)) begin
      width_eff = CWIDTH_W'(3);
    end else if (image_width > CWIDTH_W'(MAX_WIDTH)) begin
      width_eff = CWIDTH_W'(MAX_WIDTH);
    end else begin
      width_eff = image_width;
    end
    if (image_height < CHEIGHT_W'(3)) begin
      height_eff = CHEIGHT_W'(3);
    end else if (image_height > CHEIGHT_W'(MAX_HEIGHT)) begin
      height_eff = CHEIGHT_W'(MAX_HEIGHT);
    end else begin
      height_eff = image_height;
    end
  end

  assign dims.width_m1  = COL_W'(width_eff - CWIDTH_W'(1));
  assign dims.height_m1 = ROW_W'(height_eff - CHEIGHT_W'(1));

endmodule

// ----- hw/rtl/sobel_line_buf.sv -----
// Raster position counters and the two row buffers feeding the 3x3 window.
// Depends on sobel_pkg.
module sobel_line_buf import sobel_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             pix_valid,
  input  logic [PIX_W-1:0] pixel,
  input  frame_dims_t      dims,
  output logic             s1_valid,
  output logic [PIX_W-1:0] s1_pixel,
  output logic [PIX_W-1:0] top,
  output logic [PIX_W-1:0] mid,
  output pix_meta_t        s1_meta
);

  logic [PIX_W-1:0] line_one_up [MAX_WIDTH];
  logic [PIX_W-1:0] line_two_up [MAX_WIDTH];

  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] s1_col;
  logic             accept;
  logic             last_col;
  logic             last_row;

  assign accept   = pix_valid && en;
  assign last_col = (col_count >= dims.width_m1);
  assign last_row = (row_count >= dims.height_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      s1_valid  <= 1'b0;
    end else if (en) begin
      s1_valid <= pix_valid;
      if (pix_valid) begin
        if (last_col) begin
          col_count <= '0;
          row_count <= last_row ? '0 : row_count + ROW_W'(1);
        end else begin
          col_count <= col_count + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel                <= pixel;
      s1_col                  <= col_count;
      s1_meta.emit            <= (row_count >= ROW_W'(2)) && (col_count >= COL_W'(2));
      s1_meta.last_of_frame   <= last_col && last_row;
      s1_meta.center_col      <= col_count - COL_W'(1);
      s1_meta.center_row      <= row_count - ROW_W'(1);
    end
  end

  // read at accept, write back one stage later; same column recurs only a row later
  always_ff @(posedge clk) begin
    if (accept) begin
      top <= line_two_up[col_count];
      mid <= line_one_up[col_count];
    end
    if (s1_valid && en) begin
      line_one_up[s1_col] <= s1_pixel;
      line_two_up[s1_col] <= mid;
    end
  end

endmodule

// ----- hw/rtl/sobel_grad.sv -----
// 3x3 window, Sobel sums, squared magnitude, threshold compare and result register.
// Depends on sobel_pkg and sobel_res_if.
module sobel_grad import sobel_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             s1_valid,
  input  logic [PIX_W-1:0] s1_pixel,
  input  logic [PIX_W-1:0] top,
  input  logic [PIX_W-1:0] mid,
  input  pix_meta_t        s1_meta,
  input  logic [THR_W-1:0] threshold_sq,
  sobel_res_if.source      res
);

  // [row*3 + col], row 0 oldest line, col 2 newest
  logic [PIX_W-1:0] window_regs [9];

  logic             s2_valid, s3_valid, s4_valid;
  pix_meta_t        s2_meta, s3_meta, s4_meta;

  logic [PIX_W+1:0] gx_pos, gx_neg, gy_pos, gy_neg;
  logic signed [GRAD_W-1:0] gx, gy;
  logic signed [2*GRAD_W-1:0] gx_prod, gy_prod;
  logic [SQ_W-1:0]  gx_sq, gy_sq;
  logic [THR_W-1:0] mag;

  always_comb begin
    gx_pos = {2'b00, window_regs[2]} + {1'b0, window_regs[5], 1'b0} + {2'b00, window_regs[8]};
    gx_neg = {2'b00, window_regs[0]} + {1'b0, window_regs[3], 1'b0} + {2'b00, window_regs[6]};
    gy_pos = {2'b00, window_regs[6]} + {1'b0, window_regs[7], 1'b0} + {2'b00, window_regs[8]};
    gy_neg = {2'b00, window_regs[0]} + {1'b0, window_regs[1], 1'b0} + {2'b00, window_regs[2]};
    gx_prod = (2*GRAD_W)'(gx) * (2*GRAD_W)'(gx);
    gy_prod = (2*GRAD_W)'(gy) * (2*GRAD_W)'(gy);
    mag = {1'b0, gx_sq} + {1'b0, gy_sq};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      res.valid <= 1'b0;
    end else if (en) begin
      s2_valid  <= s1_valid && s1_meta.emit;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      res.valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s1_valid) begin
        for (int i = 0; i < 3; i++) begin
          window_regs[i*3]   <= window_regs[i*3+1];
          window_regs[i*3+1] <= window_regs[i*3+2];
        end
        window_regs[2] <= top;
        window_regs[5] <= mid;
        window_regs[8] <= s1_pixel;
      end
      s2_meta <= s1_meta;
      gx      <= signed'({1'b0, gx_pos}) - signed'({1'b0, gx_neg});
      gy      <= signed'({1'b0, gy_pos}) - signed'({1'b0, gy_neg});
      s3_meta <= s2_meta;
      gx_sq   <= gx_prod[SQ_W-1:0];
      gy_sq   <= gy_prod[SQ_W-1:0];
      s4_meta <= s3_meta;
      res.edge_res      <= (mag > threshold_sq);
      res.center_col    <= s4_meta.center_col;
      res.center_row    <= s4_meta.center_row;
      res.last_of_frame <= s4_meta.last_of_frame;
    end
  end

endmodule
